// ===== hw/rtl/sdfq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdfq_pkg: shared constants and helpers for the SDF grid query block
// Holds the fixed-point format, register indexes, request codes and the
// saturation and clamp helpers used by the query pipeline.
// ----------------------------------------------------------------------------
package sdfq_pkg;

  // Fixed-point format of all world and distance values.
  localparam int FRAC_BITS = 16;
  localparam logic [30:0] FONE = 31'(1 << FRAC_BITS);

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_INV_CELL  = 3'd2;
  localparam logic [2:0] REG_GRID_ROWS = 3'd3;
  localparam logic [2:0] REG_GRID_COLS = 3'd4;
  localparam logic [2:0] REG_CLEARANCE = 3'd5;

  // Request codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Grid dimension limits.
  localparam logic [6:0] DIM_MIN = 7'd2;
  localparam logic [6:0] DIM_MAX = 7'd64;

  // Distance reported by an empty grid.
  localparam logic signed [31:0] DIST_EMPTY = 32'sh7FFF_FFFF;

  // Saturation bounds for 32-bit signed results.
  localparam logic signed [71:0] SAT_HI = 72'sh7FFF_FFFF;
  localparam logic signed [71:0] SAT_LO = -72'sh8000_0000;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > SAT_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Clamp a signed grid coordinate into [0, hi].
  function automatic logic [5:0] clamp_idx(input logic signed [34:0] v,
                                           input logic [5:0] hi);
    if (v < 35'sd0) begin
      return 6'd0;
    end else if (v > $signed({29'd0, hi})) begin
      return hi;
    end
    return v[5:0];
  endfunction

  // Force a grid dimension into the supported range.
  function automatic logic [6:0] dim_fix(input logic [6:0] n);
    if (n < DIM_MIN) begin
      return DIM_MIN;
    end else if (n > DIM_MAX) begin
      return DIM_MAX;
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/sdf_grid_bilinear_query.sv =====
// ----------------------------------------------------------------------------
// sdf_grid_bilinear_query: signed distance grid with bilinear lookup
// Loads a grid of distance samples and answers point queries with the
// interpolated distance, its gradient, a safe flag and a clearance penalty.
//
//   channel   signals                                  direction
//   cfg       cfg_write, cfg_index, cfg_data           in (write only)
//   in        in_valid/in_ready, op .. query_y         in
//   out       out_valid/out_ready, distance .. pgrad   out
//
// One request enters per cycle while the pipeline advances; a query result
// leaves stage 16 and a write request updates the grid memory from stage 5,
// with no result. The sixteen-stage pipeline reads a two-copy grid memory
// with two read ports each. All stages advance together whenever the output
// register is empty or taken; a stall freezes every stage and the memory read.
// Reset clears the valid bits and written flag and sets configuration defaults.
// ----------------------------------------------------------------------------
module sdf_grid_bilinear_query #(
  parameter int GRID_CELLS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [11:0]        cell_index,
  input  logic signed [31:0] cell_value,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] distance,
  output logic signed [31:0] grad_x,
  output logic signed [31:0] grad_y,
  output logic               safe,
  output logic [30:0]        penalty,
  output logic signed [31:0] penalty_grad_x,
  output logic signed [31:0] penalty_grad_y
);

  localparam int AW = $clog2(GRID_CELLS);
  localparam int LW = (AW >= 12) ? AW + 1 : 13;
  localparam int FB = sdfq_pkg::FRAC_BITS;
  localparam logic signed [49:0] HALF50 = 50'sd1 <<< (FB - 1);

  // Configuration registers.
  logic signed [31:0] origin_x, origin_y, clearance;
  logic [30:0]        inv_cell_size;
  logic [6:0]         grid_rows, grid_cols;
  logic               grid_written;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      inv_cell_size <= sdfq_pkg::FONE;
      grid_rows     <= sdfq_pkg::DIM_MAX;
      grid_cols     <= sdfq_pkg::DIM_MAX;
      clearance     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sdfq_pkg::REG_ORIGIN_X:  origin_x      <= cfg_data;
        sdfq_pkg::REG_ORIGIN_Y:  origin_y      <= cfg_data;
        sdfq_pkg::REG_INV_CELL:  inv_cell_size <= cfg_data[30:0];
        sdfq_pkg::REG_GRID_ROWS: grid_rows     <= cfg_data[6:0];
        sdfq_pkg::REG_GRID_COLS: grid_cols     <= cfg_data[6:0];
        sdfq_pkg::REG_CLEARANCE: clearance     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective grid size and the last valid row and column.
  logic [6:0] rows_eff, cols_eff;
  logic [5:0] row_max, col_max;
  always_comb begin
    rows_eff = sdfq_pkg::dim_fix(grid_rows);
    cols_eff = sdfq_pkg::dim_fix(grid_cols);
    row_max  = 6'(rows_eff - 7'd1);
    col_max  = 6'(cols_eff - 7'd1);
  end

  // Pipeline advance: every stage moves when the output slot is empty or taken.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage registers.
  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld, s8_vld;
  logic s9_vld, s10_vld, s11_vld, s12_vld, s13_vld, s14_vld, s15_vld, s16_vld;
  logic s1_op, s2_op, s3_op, s4_op, s5_op;
  logic [11:0] s1_idx, s2_idx, s3_idx, s4_idx, s5_idx;
  logic [31:0] s1_val, s2_val, s3_val, s4_val, s5_val;
  logic signed [32:0] s1_dx, s1_dy;
  logic signed [64:0] s2_px, s2_py;
  logic signed [49:0] s3_fx, s3_fy;
  logic [5:0] s4_c0, s4_c1, s4_r0, s4_r1;
  logic [FB-1:0] s4_tx, s4_ty, s5_tx, s5_ty, s6_tx, s6_ty, s7_tx, s7_ty;
  logic [FB-1:0] s8_tx, s8_ty, s9_ty, s10_ty;
  logic [11:0] s5_i00, s5_i01, s5_i10, s5_i11;
  logic [3:0] s6_ok;
  logic s6_empty, s7_empty, s8_empty, s9_empty, s10_empty, s11_empty;
  logic signed [31:0] s7_v00, s7_v10, s8_v00, s8_v10;
  logic signed [32:0] s7_e0, s7_e1, s7_f0, s7_f1, s8_e0, s8_f0, s9_e0, s9_f0;
  logic signed [49:0] s8_ma0, s8_ma1;
  logic signed [33:0] s8_de, s8_df;
  logic signed [32:0] s9_a0, s9_a1, s10_a0, s11_a0;
  logic signed [50:0] s9_mdx, s9_mdy, s11_md;
  logic signed [33:0] s10_da;
  logic signed [34:0] s10_dx, s10_dy;
  logic signed [66:0] s11_gxp, s11_gyp;
  logic signed [31:0] s12_dist, s12_gx, s12_gy, s13_dist, s13_gx, s13_gy;
  logic signed [32:0] s13_s;
  logic signed [31:0] s14_dist, s14_gx, s14_gy, s15_dist, s15_gx, s15_gy;
  logic [31:0] s14_m;
  logic s14_safe, s15_safe;
  logic [63:0] s15_sq;
  logic signed [64:0] s15_pxp, s15_pyp;
  logic signed [31:0] s16_dist, s16_gx, s16_gy, s16_pgx, s16_pgy;
  logic s16_safe;
  logic [30:0] s16_pen;

  // Grid memory: two copies so that four samples are read per cycle while the pipeline advances.
  logic [31:0] rd00, rd01, rd10, rd11;
  logic [LW-1:0] w00, w01, w10, w11, wwr;
  logic [AW-1:0] a00, a01, a10, a11, awr;
  logic ram_we;

  always_comb begin
    w00    = LW'(s5_i00);
    w01    = LW'(s5_i01);
    w10    = LW'(s5_i10);
    w11    = LW'(s5_i11);
    wwr    = LW'(s5_idx);
    a00    = w00[AW-1:0];
    a01    = w01[AW-1:0];
    a10    = w10[AW-1:0];
    a11    = w11[AW-1:0];
    awr    = wwr[AW-1:0];
    ram_we = en && s5_vld && (s5_op == sdfq_pkg::OP_WRITE) && (wwr < LW'(GRID_CELLS));
  end

  sdfq_ram #(.WIDTH(32), .DEPTH(GRID_CELLS)) u_ram_top (
    .clk(clk), .we(ram_we), .waddr(awr), .wdata(s5_val), .re(en),
    .raddr_a(a00), .raddr_b(a01), .rdata_a(rd00), .rdata_b(rd01)
  );

  sdfq_ram #(.WIDTH(32), .DEPTH(GRID_CELLS)) u_ram_bot (
    .clk(clk), .we(ram_we), .waddr(awr), .wdata(s5_val), .re(en),
    .raddr_a(a10), .raddr_b(a11), .rdata_a(rd10), .rdata_b(rd11)
  );

  // The grid counts as loaded once a write reaches the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_written <= 1'b0;
    end else if (ram_we) begin
      grid_written <= 1'b1;
    end
  end

  // Combinational work between stages.
  logic signed [32:0] dx_c, dy_c;
  logic signed [49:0] fx_c, fy_c;
  logic signed [34:0] ix_c, iy_c;
  logic [12:0] rb0_c, rb1_c;
  logic signed [31:0] v00_c, v01_c, v10_c, v11_c;
  logic signed [31:0] dist_c, gx_c, gy_c;
  logic [31:0] m_c;
  logic [63:0] sq_hi_c;
  logic [30:0] pen_c;

  always_comb begin
    dx_c    = $signed({query_x[31], query_x}) - $signed({origin_x[31], origin_x});
    dy_c    = $signed({query_y[31], query_y}) - $signed({origin_y[31], origin_y});
    fx_c    = 50'(s2_px >>> FB) - HALF50;
    fy_c    = 50'(s2_py >>> FB) - HALF50;
    ix_c    = 35'(s3_fx >>> FB);
    iy_c    = 35'(s3_fy >>> FB);
    rb0_c   = 13'(s4_r0) * 13'(cols_eff);
    rb1_c   = 13'(s4_r1) * 13'(cols_eff);
    v00_c   = s6_ok[0] ? $signed(rd00) : 32'sd0;
    v01_c   = s6_ok[1] ? $signed(rd01) : 32'sd0;
    v10_c   = s6_ok[2] ? $signed(rd10) : 32'sd0;
    v11_c   = s6_ok[3] ? $signed(rd11) : 32'sd0;
    dist_c  = 32'(s11_a0 + 33'(s11_md >>> FB));
    gx_c    = sdfq_pkg::sat32(72'(s11_gxp >>> FB));
    gy_c    = sdfq_pkg::sat32(72'(s11_gyp >>> FB));
    m_c     = s13_s[32] ? 32'(-s13_s) : 32'd0;
    sq_hi_c = s15_sq >> FB;
    pen_c   = (sq_hi_c > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sq_hi_c[30:0];
  end

  // Valid bits; write requests leave the pipeline at the memory stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      {s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld, s8_vld} <= '0;
      {s9_vld, s10_vld, s11_vld, s12_vld, s13_vld, s14_vld, s15_vld, s16_vld} <= '0;
    end else if (en) begin
      s1_vld  <= in_valid;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      s4_vld  <= s3_vld;
      s5_vld  <= s4_vld;
      s6_vld  <= s5_vld && (s5_op == sdfq_pkg::OP_QUERY);
      s7_vld  <= s6_vld;
      s8_vld  <= s7_vld;
      s9_vld  <= s8_vld;
      s10_vld <= s9_vld;
      s11_vld <= s10_vld;
      s12_vld <= s11_vld;
      s13_vld <= s12_vld;
      s14_vld <= s13_vld;
      s15_vld <= s14_vld;
      s16_vld <= s15_vld;
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: offset from the grid origin.
      s1_op  <= op;
      s1_idx <= cell_index;
      s1_val <= cell_value;
      s1_dx  <= dx_c;
      s1_dy  <= dy_c;
      // Stage 2: scale to grid units.
      s2_op  <= s1_op;
      s2_idx <= s1_idx;
      s2_val <= s1_val;
      s2_px  <= s1_dx * $signed({1'b0, inv_cell_size});
      s2_py  <= s1_dy * $signed({1'b0, inv_cell_size});
      // Stage 3: shift cell centers by half a cell.
      s3_op  <= s2_op;
      s3_idx <= s2_idx;
      s3_val <= s2_val;
      s3_fx  <= fx_c;
      s3_fy  <= fy_c;
      // Stage 4: clamp neighbor columns and rows, split off fractions.
      s4_op  <= s3_op;
      s4_idx <= s3_idx;
      s4_val <= s3_val;
      s4_c0  <= sdfq_pkg::clamp_idx(ix_c, col_max);
      s4_c1  <= sdfq_pkg::clamp_idx(ix_c + 35'sd1, col_max);
      s4_r0  <= sdfq_pkg::clamp_idx(iy_c, row_max);
      s4_r1  <= sdfq_pkg::clamp_idx(iy_c + 35'sd1, row_max);
      s4_tx  <= s3_fx[FB-1:0];
      s4_ty  <= s3_fy[FB-1:0];
      // Stage 5: row-major sample indexes.
      s5_op  <= s4_op;
      s5_idx <= s4_idx;
      s5_val <= s4_val;
      s5_i00 <= 12'(rb0_c + 13'(s4_c0));
      s5_i01 <= 12'(rb0_c + 13'(s4_c1));
      s5_i10 <= 12'(rb1_c + 13'(s4_c0));
      s5_i11 <= 12'(rb1_c + 13'(s4_c1));
      s5_tx  <= s4_tx;
      s5_ty  <= s4_ty;
      // Stage 6: memory read in flight.
      s6_ok    <= {w11 < LW'(GRID_CELLS), w10 < LW'(GRID_CELLS),
                   w01 < LW'(GRID_CELLS), w00 < LW'(GRID_CELLS)};
      s6_empty <= !grid_written;
      s6_tx    <= s5_tx;
      s6_ty    <= s5_ty;
      // Stage 7: sample differences.
      s7_v00   <= v00_c;
      s7_v10   <= v10_c;
      s7_e0    <= 33'(v01_c) - 33'(v00_c);
      s7_e1    <= 33'(v11_c) - 33'(v10_c);
      s7_f0    <= 33'(v10_c) - 33'(v00_c);
      s7_f1    <= 33'(v11_c) - 33'(v01_c);
      s7_tx    <= s6_tx;
      s7_ty    <= s6_ty;
      s7_empty <= s6_empty;
      // Stage 8: weight the row differences along x.
      s8_ma0   <= s7_e0 * $signed({1'b0, s7_tx});
      s8_ma1   <= s7_e1 * $signed({1'b0, s7_tx});
      s8_de    <= 34'(s7_e1) - 34'(s7_e0);
      s8_df    <= 34'(s7_f1) - 34'(s7_f0);
      s8_v00   <= s7_v00;
      s8_v10   <= s7_v10;
      s8_e0    <= s7_e0;
      s8_f0    <= s7_f0;
      s8_tx    <= s7_tx;
      s8_ty    <= s7_ty;
      s8_empty <= s7_empty;
      // Stage 9: row interpolants and gradient weights.
      s9_a0    <= 33'(s8_v00) + 33'(s8_ma0 >>> FB);
      s9_a1    <= 33'(s8_v10) + 33'(s8_ma1 >>> FB);
      s9_mdx   <= s8_de * $signed({1'b0, s8_ty});
      s9_mdy   <= s8_df * $signed({1'b0, s8_tx});
      s9_e0    <= s8_e0;
      s9_f0    <= s8_f0;
      s9_ty    <= s8_ty;
      s9_empty <= s8_empty;
      // Stage 10: column difference and raw gradients.
      s10_da    <= 34'(s9_a1) - 34'(s9_a0);
      s10_a0    <= s9_a0;
      s10_dx    <= 35'(s9_e0) + 35'(s9_mdx >>> FB);
      s10_dy    <= 35'(s9_f0) + 35'(s9_mdy >>> FB);
      s10_ty    <= s9_ty;
      s10_empty <= s9_empty;
      // Stage 11: weight along y and scale gradients to world units.
      s11_md    <= s10_da * $signed({1'b0, s10_ty});
      s11_gxp   <= s10_dx * $signed({1'b0, inv_cell_size});
      s11_gyp   <= s10_dy * $signed({1'b0, inv_cell_size});
      s11_a0    <= s10_a0;
      s11_empty <= s10_empty;
      // Stage 12: distance and saturated gradients, empty grid override.
      s12_dist <= s11_empty ? sdfq_pkg::DIST_EMPTY : dist_c;
      s12_gx   <= s11_empty ? 32'sd0 : gx_c;
      s12_gy   <= s11_empty ? 32'sd0 : gy_c;
      // Stage 13: clearance margin.
      s13_s    <= $signed({s12_dist[31], s12_dist}) - $signed({clearance[31], clearance});
      s13_dist <= s12_dist;
      s13_gx   <= s12_gx;
      s13_gy   <= s12_gy;
      // Stage 14: violation magnitude, zero when safe.
      s14_m    <= m_c;
      s14_safe <= !s13_s[32];
      s14_dist <= s13_dist;
      s14_gx   <= s13_gx;
      s14_gy   <= s13_gy;
      // Stage 15: penalty products.
      s15_sq   <= 64'(s14_m) * 64'(s14_m);
      s15_pxp  <= s14_gx * $signed({1'b0, s14_m});
      s15_pyp  <= s14_gy * $signed({1'b0, s14_m});
      s15_safe <= s14_safe;
      s15_dist <= s14_dist;
      s15_gx   <= s14_gx;
      s15_gy   <= s14_gy;
      // Stage 16: output register with saturated penalty terms.
      s16_pen  <= pen_c;
      s16_pgx  <= sdfq_pkg::sat32(-(72'(s15_pxp >>> (FB - 1))));
      s16_pgy  <= sdfq_pkg::sat32(-(72'(s15_pyp >>> (FB - 1))));
      s16_safe <= s15_safe;
      s16_dist <= s15_dist;
      s16_gx   <= s15_gx;
      s16_gy   <= s15_gy;
    end
  end

  // Result port.
  assign out_valid      = s16_vld;
  assign distance       = s16_dist;
  assign grad_x         = s16_gx;
  assign grad_y         = s16_gy;
  assign safe           = s16_safe;
  assign penalty        = s16_pen;
  assign penalty_grad_x = s16_pgx;
  assign penalty_grad_y = s16_pgy;

`ifndef SYNTH
  // A safe result carries no penalty.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && safe |-> penalty == '0 && penalty_grad_x == '0 && penalty_grad_y == '0)
    else $error("safe result with nonzero penalty");

  // Once loaded, the grid stays loaded until reset.
  assert property (@(posedge clk) disable iff (rst)
    grid_written |=> grid_written)
    else $error("grid written flag dropped");

  // A stalled output freezes the pipeline; checked on the stage 6, 12 and 15 valid bits.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(s6_vld) && $stable(s15_vld) && $stable(s12_vld))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== hw/rtl/sdfq_ram.sv =====
// ----------------------------------------------------------------------------
// sdfq_ram: generic memory with one write port and two registered read ports
// Read data updates only when the read enable is high, so a stalled pipeline
// keeps its read results.
// ----------------------------------------------------------------------------
module sdfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
